FILE: hw/rtl/kped_pkg.sv
// Shared types and constants for the key press event detector.
// Used by every module below the top level and by the top level.
package kped_pkg;

    localparam int NUM_KEYS    = 32;
    localparam int PRESS_W     = 32;
    localparam int SCAN_KEYS   = (NUM_KEYS < PRESS_W) ? NUM_KEYS : PRESS_W;
    localparam int LANE_W      = 8;
    localparam int LANE_POS_W  = $clog2(LANE_W);
    localparam int NUM_LANES   = (SCAN_KEYS + LANE_W - 1) / LANE_W;
    localparam int LANE_SEL_W  = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
    localparam int SCAN_W      = NUM_LANES * LANE_W;
    localparam int KEY_IDX_W   = 5;
    localparam int KEY_CNT_W   = 6;
    localparam int TICK_W      = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int EVENT_W     = 2;
    localparam int CMP_W       = (LANE_SEL_W + LANE_POS_W > KEY_CNT_W) ?
                                 LANE_SEL_W + LANE_POS_W + 1 : KEY_CNT_W + 1;

    localparam logic [KEY_CNT_W-1:0] SCAN_LIMIT  = KEY_CNT_W'(SCAN_KEYS);
    localparam logic [TICK_W-1:0]    LONG_RESET  = TICK_W'(100);

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_UNSTABLE = 2'd1,
        PH_DOWN     = 2'd2,
        PH_LONG     = 2'd3
    } t_phase;

    typedef enum logic [EVENT_W-1:0] {
        EV_PRESS         = 2'd0,
        EV_SHORT_RELEASE = 2'd1,
        EV_LONG          = 2'd2,
        EV_LONG_RELEASE  = 2'd3
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_COUNT  = 1'b0,
        CFG_LONG_TICKS = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic                  hit;
        logic [LANE_POS_W-1:0] pos;
    } t_lane_hit;

    typedef struct packed {
        logic                 hit;
        logic [KEY_IDX_W-1:0] key;
    } t_sample;

    typedef struct packed {
        logic                 valid;
        t_event               code;
        logic [KEY_IDX_W-1:0] key;
    } t_key_event;

endpackage

FILE: hw/rtl/kped_lane.sv
// One scan lane: lowest pressed, active key within a group of LANE_W keys.
// Depends on kped_pkg.
module kped_lane (
    input  logic [kped_pkg::LANE_SEL_W-1:0] i_lane,
    input  logic [kped_pkg::LANE_W-1:0]     i_bits,
    input  logic [kped_pkg::KEY_CNT_W-1:0]  i_limit,
    output kped_pkg::t_lane_hit             o_hit
);
    import kped_pkg::*;

    logic [LANE_W-1:0] w_active;

    always_comb begin
        for (int j = 0; j < LANE_W; j++) begin
            w_active[j] = i_bits[j] &&
                (CMP_W'({i_lane, LANE_POS_W'(j)}) < CMP_W'(i_limit));
        end
    end

    always_comb begin
        o_hit = '0;
        for (int j = LANE_W - 1; j >= 0; j--) begin
            if (w_active[j]) begin
                o_hit.hit = 1'b1;
                o_hit.pos = LANE_POS_W'(j);
            end
        end
    end

endmodule

FILE: hw/rtl/kped_merge.sv
// Merge of lane results: the lowest lane with a hit gives the sampled key.
// Depends on kped_pkg.
module kped_merge (
    input  kped_pkg::t_lane_hit i_hits [kped_pkg::NUM_LANES],
    output kped_pkg::t_sample   o_sample
);
    import kped_pkg::*;

    always_comb begin
        o_sample = '0;
        for (int l = NUM_LANES - 1; l >= 0; l--) begin
            if (i_hits[l].hit) begin
                o_sample.hit = 1'b1;
                o_sample.key = KEY_IDX_W'({LANE_SEL_W'(l), i_hits[l].pos});
            end
        end
    end

endmodule

FILE: hw/rtl/kped_fsm.sv
// Debounce and press-phase state machine; one step per accepted transaction.
// Depends on kped_pkg.
module kped_fsm (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  kped_pkg::t_sample           i_sample,
    input  logic [kped_pkg::TICK_W-1:0] i_long_ticks,
    output kped_pkg::t_key_event        o_event
);
    import kped_pkg::*;

    t_phase                r_phase, n_phase;
    logic [KEY_IDX_W-1:0]  r_key, n_key;
    logic [TICK_W-1:0]     r_ticks, n_ticks;
    logic [TICK_W-1:0]     w_ticks_inc;
    logic                  w_same;

    assign w_same      = i_sample.hit && (i_sample.key == r_key);
    assign w_ticks_inc = r_ticks + TICK_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_key   <= '0;
            r_ticks <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_key   <= n_key;
            r_ticks <= n_ticks;
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_key         = r_key;
        n_ticks       = r_ticks;
        o_event.valid = 1'b0;
        o_event.code  = EV_PRESS;
        o_event.key   = r_key;
        case (r_phase)
            PH_IDLE: begin
                if (i_sample.hit) begin
                    n_key   = i_sample.key;
                    n_phase = PH_UNSTABLE;
                end
            end
            PH_UNSTABLE: begin
                n_ticks = '0;
                if (w_same) begin
                    n_phase       = PH_DOWN;
                    o_event.valid = i_step;
                    o_event.code  = EV_PRESS;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_DOWN: begin
                if (!w_same) begin
                    n_phase       = PH_IDLE;
                    n_ticks       = '0;
                    o_event.valid = i_step;
                    o_event.code  = EV_SHORT_RELEASE;
                end else begin
                    n_ticks = w_ticks_inc;
                    if (w_ticks_inc > i_long_ticks) begin
                        n_phase       = PH_LONG;
                        o_event.valid = i_step;
                        o_event.code  = EV_LONG;
                    end
                end
            end
            PH_LONG: begin
                if (!w_same) begin
                    n_phase       = PH_IDLE;
                    o_event.valid = i_step;
                    o_event.code  = EV_LONG_RELEASE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/key_press_event_detector.sv
// Top level of the key press event detector: config registers, scan lanes,
// merge, phase machine and a two-entry output buffer. Depends on kped_pkg.
//
//   channel   signals                                   direction
//   input     i_valid, o_stall, i_pressed_keys          in
//   output    o_valid, i_stall, o_event_code, o_key_index  out
//   config    i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data  in
//
// One transaction per cycle unless o_stall; its event, if any, is registered.
// The rate is set by the combinational lane encode, merge and phase update.
// Synchronous active-low reset; no clearing pass, ready at once.
// A skid entry behind the output register absorbs one stalled result;
// o_stall rises only while that entry is full.
module key_press_event_detector (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [kped_pkg::PRESS_W-1:0]     i_pressed_keys,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [kped_pkg::EVENT_W-1:0]     o_event_code,
    output logic [kped_pkg::KEY_IDX_W-1:0]   o_key_index,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [kped_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [kped_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import kped_pkg::*;

    logic [KEY_CNT_W-1:0]  r_key_count;
    logic [TICK_W-1:0]     r_long_ticks;
    logic [KEY_CNT_W-1:0]  w_limit;
    logic [SCAN_W-1:0]     w_scan;
    t_lane_hit             w_hits [NUM_LANES];
    t_sample               w_sample;
    t_key_event            w_event;
    logic                  w_accept;
    logic                  w_take;
    logic                  r_out_valid;
    t_event                r_out_code;
    logic [KEY_IDX_W-1:0]  r_out_key;
    logic                  r_skd_valid;
    t_event                r_skd_code;
    logic [KEY_IDX_W-1:0]  r_skd_key;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count  <= '0;
            r_long_ticks <= LONG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_KEY_COUNT:  r_key_count  <= i_cfg_data[KEY_CNT_W-1:0];
                CFG_LONG_TICKS: r_long_ticks <= i_cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_limit = (r_key_count > SCAN_LIMIT) ? SCAN_LIMIT : r_key_count;
    assign w_scan  = SCAN_W'(i_pressed_keys);

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        kped_lane u_lane (
            .i_lane  (LANE_SEL_W'(l)),
            .i_bits  (w_scan[l*LANE_W +: LANE_W]),
            .i_limit (w_limit),
            .o_hit   (w_hits[l])
        );
    end

    kped_merge u_merge (
        .i_hits   (w_hits),
        .o_sample (w_sample)
    );

    assign o_stall  = r_skd_valid;
    assign w_accept = i_valid && !r_skd_valid;
    assign w_take   = r_out_valid && !i_stall;

    kped_fsm u_fsm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_accept),
        .i_sample     (w_sample),
        .i_long_ticks (r_long_ticks),
        .o_event      (w_event)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (!r_out_valid || w_take) begin
            if (r_skd_valid) begin
                r_out_valid <= 1'b1;
                r_skd_valid <= 1'b0;
            end else begin
                r_out_valid <= w_event.valid;
            end
        end else if (w_event.valid) begin
            r_skd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_take) begin
            if (r_skd_valid) begin
                r_out_code <= r_skd_code;
                r_out_key  <= r_skd_key;
            end else begin
                r_out_code <= w_event.code;
                r_out_key  <= w_event.key;
            end
        end else if (w_event.valid) begin
            r_skd_code <= w_event.code;
            r_skd_key  <= w_event.key;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_event_code = r_out_code;
    assign o_key_index  = r_out_key;

endmodule
